[hdl/per_host_dispatch_limiter_unit_assert.svh]
// Assertion macros for the per-host dispatch limiter.
`ifndef PER_HOST_DISPATCH_LIMITER_UNIT_ASSERT_SVH
`define PER_HOST_DISPATCH_LIMITER_UNIT_ASSERT_SVH

// holds in the same cycle
`define PHDL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("phdl assertion failed");

// holds in the following cycle
`define PHDL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("phdl assertion failed");

`endif

[hdl/phdl_pkg.sv]
// Shared types and constants of the per-host dispatch limiter.
package phdl_pkg;

	localparam int HOST_W  = 64;
	localparam int TAG_W   = 32;
	localparam int FC_W    = 5;
	localparam int LIM_W   = 4;
	localparam int FIDX_W  = 4;
	localparam int STAMP_W = 32;
	localparam int CFG_IDX_W = 1;

	localparam int MAX_FETCHERS = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_FETCHER_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PER_HOST_LIMIT = 1'b1;

	localparam logic [FC_W-1:0]  FETCHER_COUNT_RST  = 5'd4;
	localparam logic [LIM_W-1:0] PER_HOST_LIMIT_RST = 4'd10;

	typedef struct packed {
		logic [HOST_W-1:0] host;
		logic [TAG_W-1:0]  tag;
	} req_t;

	typedef struct packed {
		logic            done;
		logic [FC_W-1:0] rem;
	} rem_stat_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_SCAN,
		BK_UPD,
		BK_OUT
	} bk_state_t;

endpackage

[hdl/phdl_front.sv]
// Front end: accepts request beats into a two-entry queue.
module phdl_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  phdl_pkg::req_t       in_req,
	output logic                 req_valid,
	input  logic                 req_ready,
	output phdl_pkg::req_t       req
);

	phdl_pkg::req_t buf_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign req_valid = (cnt_q != 2'd0);
	assign req       = buf_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= in_req;
	end

endmodule

[hdl/phdl_rem.sv]
// Bit-serial remainder of the send counter by the fetcher count.
module phdl_rem (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [phdl_pkg::STAMP_W-1:0]       num,
	input  logic [phdl_pkg::FC_W-1:0]          den,
	output phdl_pkg::rem_stat_t                stat
);

	logic [phdl_pkg::STAMP_W-1:0] n_q;
	logic [phdl_pkg::FC_W-1:0]    r_q;
	logic [5:0]                   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [phdl_pkg::FC_W:0]      sh;
	logic [phdl_pkg::FC_W-1:0]    rn;

	always_comb begin
		sh = {r_q, n_q[phdl_pkg::STAMP_W-1]};
		if (sh >= {1'b0, den}) rn = phdl_pkg::FC_W'(sh - {1'b0, den});
		else                   rn = sh[phdl_pkg::FC_W-1:0];
	end

	assign stat.done = done_q;
	assign stat.rem  = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 6'd0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= 6'(phdl_pkg::STAMP_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			r_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[phdl_pkg::STAMP_W-2:0], 1'b0};
			r_q <= rn;
		end
	end

endmodule

[hdl/phdl_back.sv]
// Back end: table sweep and lookup, dispatch decision and result register.
module phdl_back #(
	parameter int TABLE_DEPTH = 32,
	parameter int OCC_W       = 6
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  phdl_pkg::req_t                   req,
	input  logic [phdl_pkg::FC_W-1:0]        fc,
	input  logic [phdl_pkg::LIM_W-1:0]       limit,
	input  logic                             fc_wr,
	output logic [OCC_W-1:0]                 occ,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [phdl_pkg::TAG_W-1:0]       tag_out,
	output logic                             dispatched,
	output logic [phdl_pkg::FIDX_W-1:0]      fetcher_index
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	phdl_pkg::bk_state_t state_q, state_d;
	phdl_pkg::rem_stat_t rstat;

	logic [phdl_pkg::HOST_W-1:0]  cur_host_q;
	logic [phdl_pkg::TAG_W-1:0]   cur_tag_q;
	logic [phdl_pkg::FC_W-1:0]    rem_q;
	logic                         rem_ok_q;
	logic [phdl_pkg::STAMP_W-1:0] total_q;
	logic [phdl_pkg::FC_W-1:0]    nf_q;
	logic [IDX_W-1:0]             head_q;
	logic [OCC_W-1:0]             occ_q;
	logic [TABLE_DEPTH-1:0]       valid_q;

	logic [phdl_pkg::HOST_W-1:0]  host_mem  [TABLE_DEPTH];
	logic [phdl_pkg::STAMP_W-1:0] stamp_mem [TABLE_DEPTH];
	logic [phdl_pkg::LIM_W-1:0]   cnt_mem   [TABLE_DEPTH];
	logic [IDX_W-1:0]             ring_mem  [TABLE_DEPTH];

	logic [phdl_pkg::HOST_W-1:0]  host_rd_q;
	logic [phdl_pkg::STAMP_W-1:0] stamp_rd_q;
	logic [phdl_pkg::LIM_W-1:0]   cnt_rd_q;
	logic [IDX_W-1:0]             ring_rd_q;

	logic [IDX_W:0]               scan_q;
	logic                         rd_vld_s1;
	logic [IDX_W-1:0]             rd_idx_s1;

	logic                         hit_q;
	logic [IDX_W-1:0]             hit_idx_q;
	logic [phdl_pkg::LIM_W-1:0]   hit_cnt_q;
	logic                         free_q;
	logic [IDX_W-1:0]             free_idx_q;

	logic                         res_disp_q;
	logic [phdl_pkg::FIDX_W-1:0]  res_fidx_q;

	logic                         out_valid_q;
	logic [phdl_pkg::TAG_W-1:0]   out_tag_q;
	logic                         out_disp_q;
	logic [phdl_pkg::FIDX_W-1:0]  out_fidx_q;

	// decoded strobes
	logic                         take;
	logic                         div_start;
	logic                         iss;
	logic                         load_out;

	logic                         sweep;
	logic                         sw_clr;
	logic [phdl_pkg::LIM_W-1:0]   cnt_eff;
	logic                         send;
	logic                         evict;
	logic [IDX_W-1:0]             old_idx;
	logic [IDX_W-1:0]             head1;
	logic [OCC_W-1:0]             occ1;
	logic [IDX_W-1:0]             slot;
	logic [TABLE_DEPTH-1:0]       valid_nxt;
	logic [OCC_W:0]               ring_sum;
	logic [IDX_W-1:0]             ring_wa;
	logic [phdl_pkg::FC_W-1:0]    f_sel;
	logic [phdl_pkg::FC_W-1:0]    f_inc;
	logic [phdl_pkg::FC_W-1:0]    nf_nxt;
	logic [phdl_pkg::FC_W-1:0]    rem_inc;
	logic                         cnt_we;
	logic [IDX_W-1:0]             cnt_wa;
	logic [phdl_pkg::LIM_W-1:0]   cnt_wd;

	phdl_rem u_rem (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (total_q),
		.den   (fc),
		.stat  (rstat)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			phdl_pkg::BK_IDLE: begin
				if (req_valid) state_d = rem_ok_q ? phdl_pkg::BK_SCAN : phdl_pkg::BK_DIV;
			end
			phdl_pkg::BK_DIV: begin
				if (rstat.done) state_d = phdl_pkg::BK_SCAN;
			end
			phdl_pkg::BK_SCAN: begin
				if (rd_vld_s1 && rd_idx_s1 == IDX_W'(TABLE_DEPTH - 1))
					state_d = phdl_pkg::BK_UPD;
			end
			phdl_pkg::BK_UPD: state_d = phdl_pkg::BK_OUT;
			phdl_pkg::BK_OUT: begin
				if (!out_valid_q || out_ready) state_d = phdl_pkg::BK_IDLE;
			end
			default: state_d = phdl_pkg::BK_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		take      = 1'b0;
		div_start = 1'b0;
		iss       = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			phdl_pkg::BK_IDLE: begin
				take      = req_valid;
				div_start = req_valid && !rem_ok_q;
			end
			phdl_pkg::BK_DIV: ;
			phdl_pkg::BK_SCAN: iss = (scan_q < (IDX_W + 1)'(TABLE_DEPTH));
			phdl_pkg::BK_UPD: ;
			phdl_pkg::BK_OUT: load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign req_ready = (state_q == phdl_pkg::BK_IDLE);

	// sweep and lookup on returned entry
	always_comb begin
		sweep   = (rem_q == '0);
		sw_clr  = sweep && valid_q[rd_idx_s1] && ((total_q - stamp_rd_q) > 32'(fc));
		cnt_eff = sw_clr ? '0 : cnt_rd_q;
	end

	// update decision
	always_comb begin
		send    = !hit_q || (hit_cnt_q < limit);
		evict   = !hit_q && (occ_q != '0) &&
		          ((32'(occ_q) > 32'(fc)) || (occ_q == OCC_W'(TABLE_DEPTH)));
		old_idx = ring_rd_q;
		head1   = head_q;
		occ1    = occ_q;
		if (evict) begin
			head1 = (head_q == IDX_W'(TABLE_DEPTH - 1)) ? '0 : head_q + 1'b1;
			occ1  = occ_q - 1'b1;
		end
		slot = free_idx_q;
		if (evict && (!free_q || old_idx < free_idx_q)) slot = old_idx;
		valid_nxt = valid_q;
		if (evict) valid_nxt[old_idx] = 1'b0;
		valid_nxt[slot] = 1'b1;
		ring_sum = (OCC_W + 1)'(head1) + (OCC_W + 1)'(occ1);
		if (ring_sum >= (OCC_W + 1)'(TABLE_DEPTH))
			ring_wa = IDX_W'(ring_sum - (OCC_W + 1)'(TABLE_DEPTH));
		else
			ring_wa = IDX_W'(ring_sum);
		f_sel   = (nf_q >= fc) ? '0 : nf_q;
		f_inc   = f_sel + 1'b1;
		nf_nxt  = (f_inc >= fc) ? '0 : f_inc;
		rem_inc = ((rem_q + 1'b1) == fc) ? '0 : rem_q + 1'b1;
	end

	// send count write port
	always_comb begin
		cnt_we = 1'b0;
		cnt_wa = rd_idx_s1;
		cnt_wd = '0;
		if (state_q == phdl_pkg::BK_SCAN && rd_vld_s1 && sw_clr) begin
			cnt_we = 1'b1;
		end else if (state_q == phdl_pkg::BK_UPD) begin
			if (hit_q) begin
				cnt_we = send;
				cnt_wa = hit_idx_q;
				cnt_wd = hit_cnt_q + 1'b1;
			end else begin
				cnt_we = 1'b1;
				cnt_wa = slot;
				cnt_wd = phdl_pkg::LIM_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		host_rd_q  <= host_mem[scan_q[IDX_W-1:0]];
		stamp_rd_q <= stamp_mem[scan_q[IDX_W-1:0]];
		cnt_rd_q   <= cnt_mem[scan_q[IDX_W-1:0]];
		ring_rd_q  <= ring_mem[head_q];
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		if (state_q == phdl_pkg::BK_UPD && !hit_q) begin
			host_mem[slot]    <= cur_host_q;
			stamp_mem[slot]   <= total_q;
			ring_mem[ring_wa] <= slot;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_host_q <= req.host;
			cur_tag_q  <= req.tag;
		end
		rd_idx_s1 <= scan_q[IDX_W-1:0];
		if (state_q == phdl_pkg::BK_UPD) begin
			res_disp_q <= send;
			res_fidx_q <= send ? f_sel[phdl_pkg::FIDX_W-1:0] : '0;
		end
		if (load_out) begin
			out_tag_q  <= cur_tag_q;
			out_disp_q <= res_disp_q;
			out_fidx_q <= res_fidx_q;
		end
		if (state_q == phdl_pkg::BK_SCAN && rd_vld_s1) begin
			if (valid_q[rd_idx_s1] && host_rd_q == cur_host_q && !hit_q) begin
				hit_idx_q <= rd_idx_s1;
				hit_cnt_q <= cnt_eff;
			end
			if (!valid_q[rd_idx_s1] && !free_q) free_idx_q <= rd_idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= phdl_pkg::BK_IDLE;
			rem_q       <= '0;
			rem_ok_q    <= 1'b1;
			total_q     <= '0;
			nf_q        <= '0;
			head_q      <= '0;
			occ_q       <= '0;
			valid_q     <= '0;
			scan_q      <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= iss;
			if (fc_wr)
				rem_ok_q <= 1'b0;
			else if (state_q == phdl_pkg::BK_DIV && rstat.done)
				rem_ok_q <= 1'b1;
			else if (state_q == phdl_pkg::BK_UPD && send && total_q == '1)
				rem_ok_q <= 1'b0;
			if (state_q == phdl_pkg::BK_DIV && rstat.done) rem_q <= rstat.rem;
			if (state_q == phdl_pkg::BK_IDLE) begin
				scan_q <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (iss) begin
				scan_q <= scan_q + 1'b1;
			end
			if (state_q == phdl_pkg::BK_SCAN && rd_vld_s1) begin
				if (valid_q[rd_idx_s1] && host_rd_q == cur_host_q) hit_q <= 1'b1;
				if (!valid_q[rd_idx_s1]) free_q <= 1'b1;
			end
			if (state_q == phdl_pkg::BK_UPD) begin
				if (!hit_q) begin
					valid_q <= valid_nxt;
					head_q  <= head1;
					occ_q   <= occ1 + 1'b1;
				end
				if (send) begin
					nf_q    <= nf_nxt;
					total_q <= total_q + 1'b1;
					rem_q   <= rem_inc;
				end
			end
			if (load_out)                    out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
		end
	end

	assign occ           = occ_q;
	assign out_valid     = out_valid_q;
	assign tag_out       = out_tag_q;
	assign dispatched    = out_disp_q;
	assign fetcher_index = out_fidx_q;

endmodule

[hdl/per_host_dispatch_limiter_unit.sv]
// Top level of the per-host dispatch limiter.
// One request beat gives exactly one result beat, in order. The block works
// on one request at a time: after the front queue, a request is taken, walks
// the whole host table (sweep and lookup share the single read port of the
// table memories), passes an update step and is then loaded into the result
// register. After a write to fetcher_count, or when the send counter wraps,
// the next request first recomputes the send counter modulo the fetcher
// count in the bit-serial remainder unit. Up to two requests queue in front
// while one is being worked on. No clearing pass is needed after reset.
`include "per_host_dispatch_limiter_unit_assert.svh"

module per_host_dispatch_limiter_unit #(
	parameter int TABLE_DEPTH  = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [phdl_pkg::HOST_W-1:0]     host_key,
	input  logic [phdl_pkg::TAG_W-1:0]      request_tag,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [phdl_pkg::TAG_W-1:0]      tag_out,
	output logic                            dispatched,
	output logic [phdl_pkg::FIDX_W-1:0]     fetcher_index,
	input  logic                            cfg_we,
	input  logic [phdl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [phdl_pkg::FC_W-1:0]       cfg_data
);

	localparam int OCC_W = $clog2(TABLE_DEPTH + 1);

	phdl_pkg::req_t in_req;
	phdl_pkg::req_t req;
	logic           req_valid;
	logic           req_ready;

	logic [phdl_pkg::FC_W-1:0]  fc_reg_q;
	logic [phdl_pkg::LIM_W-1:0] lim_q;
	logic [phdl_pkg::FC_W-1:0]  fc;
	logic                       fc_wr;
	logic [OCC_W-1:0]           occ;

	assign in_req.host = host_key;
	assign in_req.tag  = request_tag;

	always_comb begin
		fc_wr = 1'b0;
		unique case (cfg_index)
			phdl_pkg::CFG_FETCHER_COUNT:  fc_wr = cfg_we;
			phdl_pkg::CFG_PER_HOST_LIMIT: fc_wr = 1'b0;
			default:                      fc_wr = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_reg_q <= phdl_pkg::FETCHER_COUNT_RST;
			lim_q    <= phdl_pkg::PER_HOST_LIMIT_RST;
		end else if (cfg_we) begin
			if (cfg_index == phdl_pkg::CFG_FETCHER_COUNT) fc_reg_q <= cfg_data;
			else lim_q <= cfg_data[phdl_pkg::LIM_W-1:0];
		end
	end

	always_comb begin
		if (fc_reg_q == '0)                             fc = phdl_pkg::FC_W'(1);
		else if (32'(fc_reg_q) > phdl_pkg::MAX_FETCHERS) fc = phdl_pkg::FC_W'(phdl_pkg::MAX_FETCHERS);
		else                                            fc = fc_reg_q;
	end

	phdl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_req   (in_req),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req)
	);

	phdl_back #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.OCC_W      (OCC_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req          (req),
		.fc           (fc),
		.limit        (lim_q),
		.fc_wr        (fc_wr),
		.occ          (occ),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.tag_out      (tag_out),
		.dispatched   (dispatched),
		.fetcher_index(fetcher_index)
	);

	`PHDL_ASSERT_NOW(a_occ_bound, 1'b1, occ <= OCC_W'(TABLE_DEPTH))
	`PHDL_ASSERT_NOW(a_defer_idx, out_valid && !dispatched, fetcher_index == '0)
	`PHDL_ASSERT_NEXT(a_one_taken, req_valid && req_ready, !req_ready)

endmodule
